>>> sv/slpg_pkg.sv
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared types and constants for the status LED pattern generator.
// ----------------------------------------------------------------------------
package slpg_pkg;

	// status codes carried by each millisecond tick
	localparam logic [2:0] ST_INIT     = 3'd0;
	localparam logic [2:0] ST_NORMAL   = 3'd1;
	localparam logic [2:0] ST_WARNING  = 3'd2;
	localparam logic [2:0] ST_ERROR    = 3'd3;
	localparam logic [2:0] ST_CRITICAL = 3'd4;
	localparam logic [2:0] ST_AP       = 3'd5;
	localparam logic [2:0] ST_UPDATING = 3'd6;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 10;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t REG_ENABLE       = 3'd0;
	localparam cfg_idx_t REG_FAST_HALF    = 3'd1;
	localparam cfg_idx_t REG_SLOW_HALF    = 3'd2;
	localparam cfg_idx_t REG_CRIT_HALF    = 3'd3;
	localparam cfg_idx_t REG_UPD_HALF     = 3'd4;
	localparam cfg_idx_t REG_BREATH_STEP  = 3'd5;
	localparam cfg_idx_t REG_BREATH_INTVL = 3'd6;

	typedef logic [9:0] half_t;
	typedef logic [7:0] duty_t;

	// reset values
	localparam half_t RST_FAST_HALF    = 10'd100;
	localparam half_t RST_SLOW_HALF    = 10'd500;
	localparam half_t RST_CRIT_HALF    = 10'd100;
	localparam half_t RST_UPD_HALF     = 10'd200;
	localparam duty_t RST_BREATH_STEP  = 8'd5;
	localparam half_t RST_BREATH_INTVL = 10'd10;
	localparam half_t RST_HALF_PERIOD  = 10'd500;
	localparam duty_t DUTY_MAX         = 8'd255;

endpackage

>>> sv/slpg_if.sv
// ----------------------------------------------------------------------------
// slpg channel interfaces
// Valid/ready channels for status ticks, LED drive results and register writes.
// ----------------------------------------------------------------------------
interface slpg_status_if;
	logic       valid;
	logic       ready;
	logic [2:0] status_code;

	modport source (output valid, output status_code, input ready);
	modport sink (input valid, input status_code, output ready);
endinterface

interface slpg_result_if;
	logic       valid;
	logic       ready;
	logic       pin_is_pwm;
	logic       pin_level;
	logic [7:0] duty;

	modport source (output valid, output pin_is_pwm, output pin_level, output duty, input ready);
	modport sink (input valid, input pin_is_pwm, input pin_level, input duty, output ready);
endinterface

interface slpg_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [slpg_pkg::CFG_IDX_W-1:0]  index;
	logic [slpg_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/status_led_pattern_generator.sv
// ----------------------------------------------------------------------------
// status_led_pattern_generator
// Turns millisecond status ticks into an LED drive: blink, solid or breathing.
// ----------------------------------------------------------------------------
//  channel   role    payload
//  status    sink    status_code (one transaction per millisecond tick)
//  result    source  pin_is_pwm, pin_level, duty (one per tick)
//  cfg       sink    index, data (register write, always ready)
//
//  One tick per clock cycle while status.ready is high; its result is in the
//  output register on the next cycle. The pattern state updates in the accepting cycle.
//  Reset sets config registers, pattern state and result valid to power-up values, not the payload.
//  status.ready drops only while a result waits unread in the output register.
// ----------------------------------------------------------------------------
module status_led_pattern_generator #(
	parameter int COUNT_BITS = 11
) (
	input  logic clk,
	input  logic arst_n,
	slpg_status_if.sink   status,
	slpg_result_if.source result,
	slpg_cfg_if.sink      cfg
);
	import slpg_pkg::*;

	localparam int CMP_W = (COUNT_BITS > 10) ? COUNT_BITS : 10;
	localparam logic [COUNT_BITS-1:0] ELAPSED_MAX = {COUNT_BITS{1'b1}};

	// configuration registers
	logic  en_q;
	half_t fast_half_q, slow_half_q, crit_half_q, upd_half_q, breath_intvl_q;
	duty_t breath_step_q;

	// pattern state
	logic [2:0]            last_code_q;
	logic [COUNT_BITS-1:0] elapsed_q;
	half_t                 half_period_q;
	logic                  led_flag_q;
	duty_t                 breath_level_q;
	logic                  rising_q;
	logic                  drive_pwm_q;
	logic                  drive_level_q;

	// output register
	logic  out_valid_q;
	logic  out_pwm_q;
	logic  out_level_q;
	duty_t out_duty_q;

	logic in_acc;

	// next-state values
	logic [2:0]            last_code_d;
	logic [COUNT_BITS-1:0] elapsed_d;
	half_t                 half_period_d;
	logic                  led_flag_d;
	duty_t                 breath_level_d;
	logic                  rising_d;
	logic                  drive_pwm_d;
	logic                  drive_level_d;

	assign status.ready = !out_valid_q || result.ready;
	assign in_acc = status.valid && status.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q           <= 1'b1;
			fast_half_q    <= RST_FAST_HALF;
			slow_half_q    <= RST_SLOW_HALF;
			crit_half_q    <= RST_CRIT_HALF;
			upd_half_q     <= RST_UPD_HALF;
			breath_step_q  <= RST_BREATH_STEP;
			breath_intvl_q <= RST_BREATH_INTVL;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ENABLE:       en_q           <= cfg.data[0];
				REG_FAST_HALF:    fast_half_q    <= cfg.data;
				REG_SLOW_HALF:    slow_half_q    <= cfg.data;
				REG_CRIT_HALF:    crit_half_q    <= cfg.data;
				REG_UPD_HALF:     upd_half_q     <= cfg.data;
				REG_BREATH_STEP:  breath_step_q  <= cfg.data[7:0];
				REG_BREATH_INTVL: breath_intvl_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [2:0]            code;
		logic [COUNT_BITS-1:0] el;
		logic [8:0]            sum;

		code = status.status_code;
		last_code_d    = last_code_q;
		el             = elapsed_q;
		half_period_d  = half_period_q;
		led_flag_d     = led_flag_q;
		breath_level_d = breath_level_q;
		rising_d       = rising_q;
		drive_pwm_d    = drive_pwm_q;
		drive_level_d  = drive_level_q;
		sum = {1'b0, breath_level_q} + {1'b0, breath_step_q};

		if (en_q) begin
			if (el != ELAPSED_MAX) el = el + 1'b1;

			// load the new code's pattern
			if (code != last_code_q) begin
				last_code_d = code;
				case (code)
					ST_INIT, ST_ERROR: begin
						half_period_d = fast_half_q;
						el = '0;
					end
					ST_NORMAL: begin
						drive_pwm_d   = 1'b0;
						drive_level_d = 1'b1;
						led_flag_d    = 1'b1;
					end
					ST_WARNING: begin
						half_period_d = slow_half_q;
						el = '0;
					end
					ST_CRITICAL: begin
						half_period_d = crit_half_q;
						el = '0;
					end
					ST_AP: begin
						breath_level_d = '0;
						rising_d = 1'b1;
						el = '0;
						sum = {1'b0, breath_step_q};
					end
					ST_UPDATING: begin
						half_period_d = upd_half_q;
						el = '0;
					end
					default: ;
				endcase
			end

			// advance the current pattern
			if (code == ST_AP) begin
				if (CMP_W'(el) > CMP_W'(breath_intvl_q)) begin
					el = '0;
					drive_pwm_d = 1'b1;
					if (rising_d) begin
						if (sum >= {1'b0, DUTY_MAX}) begin
							breath_level_d = DUTY_MAX;
							rising_d = 1'b0;
						end else begin
							breath_level_d = sum[7:0];
						end
					end else if (breath_level_d >= breath_step_q) begin
						breath_level_d = breath_level_d - breath_step_q;
					end else begin
						breath_level_d = '0;
						rising_d = 1'b1;
					end
				end
			end else if (code == ST_NORMAL) begin
				if (!led_flag_d) begin
					led_flag_d    = 1'b1;
					drive_pwm_d   = 1'b0;
					drive_level_d = 1'b1;
				end
			end else if (CMP_W'(el) > CMP_W'(half_period_d)) begin
				el = '0;
				led_flag_d    = !led_flag_d;
				drive_pwm_d   = 1'b0;
				drive_level_d = led_flag_d;
			end
		end
		elapsed_d = el;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_code_q    <= ST_INIT;
			elapsed_q      <= '0;
			half_period_q  <= RST_HALF_PERIOD;
			led_flag_q     <= 1'b0;
			breath_level_q <= '0;
			rising_q       <= 1'b1;
			drive_pwm_q    <= 1'b0;
			drive_level_q  <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (in_acc) begin
				last_code_q    <= last_code_d;
				elapsed_q      <= elapsed_d;
				half_period_q  <= half_period_d;
				led_flag_q     <= led_flag_d;
				breath_level_q <= breath_level_d;
				rising_q       <= rising_d;
				drive_pwm_q    <= drive_pwm_d;
				drive_level_q  <= drive_level_d;
				out_valid_q    <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded with each tick
	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_pwm_q   <= drive_pwm_d;
			out_level_q <= drive_pwm_d ? 1'b0 : drive_level_d;
			out_duty_q  <= drive_pwm_d ? breath_level_d : '0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.pin_is_pwm = out_pwm_q;
	assign result.pin_level  = out_level_q;
	assign result.duty       = out_duty_q;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |-> !status.ready)
		else $error("tick accepted while result held");

	a_pwm_level_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_pwm_q |-> !out_level_q)
		else $error("digital level set during PWM drive");

	a_digital_duty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_pwm_q |-> out_duty_q == '0)
		else $error("duty nonzero during digital drive");

	a_code_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && en_q |=> last_code_q == $past(status.status_code))
		else $error("last code not updated");

endmodule
